// File: rtl/sbm_pkg.sv
`timescale 1ns / 1ps
// sbm_pkg: types, codes and helpers for the serial loaded bank mapper
// no dependencies; imported by the translation unit, top level and checker

package sbm_pkg;

  typedef enum logic [2:0] {
    KIND_CPU_RD  = 3'd0,
    KIND_CPU_WR  = 3'd1,
    KIND_PPU_RD  = 3'd2,
    KIND_PPU_WR  = 3'd3,
    KIND_NT_FOLD = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    TGT_NONE    = 3'd0,
    TGT_PRG_RAM = 3'd1,
    TGT_PRG_ROM = 3'd2,
    TGT_CHR     = 3'd3,
    TGT_NT      = 3'd4
  } target_e;

  typedef enum logic [1:0] {
    MIR_SINGLE_LO = 2'd0,
    MIR_SINGLE_HI = 2'd1,
    MIR_VERT      = 2'd2,
    MIR_HORIZ     = 2'd3
  } mirror_e;

  typedef enum logic [1:0] {
    CFG_PRG_ROM_LOG2 = 2'd0,
    CFG_CHR_LOG2     = 2'd1,
    CFG_PRG_RAM_LOG2 = 2'd2,
    CFG_INIT_MIRROR  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REG_CONTROL = 2'd0,
    REG_CHR0    = 2'd1,
    REG_CHR1    = 2'd2,
    REG_PRG     = 2'd3
  } reg_sel_e;

  typedef enum logic [1:0] {
    PRG_MODE_32K_A    = 2'd0,
    PRG_MODE_32K_B    = 2'd1,
    PRG_MODE_FIX_FIRST = 2'd2,
    PRG_MODE_FIX_LAST  = 2'd3
  } prg_mode_e;

  localparam int unsigned AddrW      = 16;
  localparam int unsigned PhysW      = 18;
  localparam int unsigned CfgDataW   = 5;
  localparam int unsigned LoadLast   = 4;

  localparam logic [4:0] PrgRomLog2Rst = 5'd17;
  localparam logic [4:0] ChrLog2Rst    = 5'd13;
  localparam logic [3:0] PrgRamLog2Rst = 4'd13;

  typedef struct packed {
    logic [4:0] prg_rom_lg;
    logic [4:0] chr_lg;
    logic [3:0] prg_ram_lg;
    mirror_e    init_mirror;
  } cfg_t;

  typedef struct packed {
    logic [4:0] loader_bits;
    logic [2:0] loader_count;
    prg_mode_e  prg_mode;
    logic       chr_mode;
    logic [4:0] chr_bank_low;
    logic [4:0] chr_bank_high;
    logic [3:0] prg_bank_sel;
    logic       ram_disable;
    mirror_e    mirror_mode;
  } state_t;

  typedef struct packed {
    target_e          target;
    logic [PhysW-1:0] phys;
    logic             strobe;
    logic [7:0]       wr_byte;
    mirror_e          mirror;
  } result_t;

  // all ones below min(lg, 18)
  function automatic logic [PhysW-1:0] size_mask(input logic [4:0] lg);
    logic [PhysW-1:0] m;
    for (int i = 0; i < PhysW; i++) begin
      m[i] = (5'(i) < lg);
    end
    return m;
  endfunction

endpackage

// File: rtl/sbm_xlate.sv
`timescale 1ns / 1ps
// sbm_xlate: address translation, nametable fold and serial register load
// depends on sbm_pkg

module sbm_xlate import sbm_pkg::*; (
  input  cfg_t             cfg_i,
  input  state_t           state_i,
  input  logic [2:0]       kind_i,
  input  logic [AddrW-1:0] address_i,
  input  logic [7:0]       write_data_i,
  output state_t           state_o,
  output result_t          result_o
);

  logic [PhysW-1:0] rom_mask;
  logic [PhysW-1:0] chr_mask;
  logic [PhysW-1:0] ram_mask;
  logic [PhysW-1:0] last_base;
  logic [PhysW-1:0] prg_raw;
  logic [PhysW-1:0] chr_raw;
  logic [AddrW-1:0] nt_addr;
  logic [4:0]       bits_n;
  kind_e            kind;

  assign kind      = kind_e'(kind_i);
  assign rom_mask  = size_mask(cfg_i.prg_rom_lg);
  assign chr_mask  = size_mask(cfg_i.chr_lg);
  assign ram_mask  = size_mask({1'b0, cfg_i.prg_ram_lg});
  assign last_base = (rom_mask + PhysW'(1)) - PhysW'(18'h04000);
  assign bits_n    = {write_data_i[0], state_i.loader_bits[4:1]};

  always_comb begin
    case (state_i.prg_mode)
      PRG_MODE_FIX_FIRST: begin
        prg_raw = address_i[14] ? {state_i.prg_bank_sel, address_i[13:0]}
                                : {4'd0, address_i[13:0]};
      end
      PRG_MODE_FIX_LAST: begin
        prg_raw = address_i[14] ? last_base + {4'd0, address_i[13:0]}
                                : {state_i.prg_bank_sel, address_i[13:0]};
      end
      default: begin
        prg_raw = {state_i.prg_bank_sel[3:1], address_i[14:0]};
      end
    endcase
  end

  always_comb begin
    if (!state_i.chr_mode) begin
      chr_raw = {1'b0, state_i.chr_bank_low[4:1], address_i[12:0]};
    end else if (address_i[12]) begin
      chr_raw = {1'b0, state_i.chr_bank_high, address_i[11:0]};
    end else begin
      chr_raw = {1'b0, state_i.chr_bank_low, address_i[11:0]};
    end
  end

  // nametable fold by 1K quadrant
  always_comb begin
    nt_addr = address_i;
    case (state_i.mirror_mode)
      MIR_VERT: begin
        if (address_i[15:11] == 5'b00101) nt_addr = address_i - 16'h0800;
      end
      MIR_HORIZ: begin
        if (address_i[15:10] == 6'b001001) nt_addr = address_i - 16'h0400;
        if (address_i[15:10] == 6'b001011) nt_addr = address_i - 16'h0800;
      end
      MIR_SINGLE_LO: begin
        if (address_i[15:10] == 6'b001001) nt_addr = address_i - 16'h0400;
        if (address_i[15:10] == 6'b001010) nt_addr = address_i - 16'h0800;
        if (address_i[15:10] == 6'b001011) nt_addr = address_i - 16'h0C00;
      end
      default: begin
        if (address_i[15:10] == 6'b001000) nt_addr = address_i + 16'h0400;
        if (address_i[15:10] == 6'b001010) nt_addr = address_i - 16'h0400;
        if (address_i[15:10] == 6'b001011) nt_addr = address_i - 16'h0800;
      end
    endcase
  end

  always_comb begin
    state_o         = state_i;
    result_o.target = TGT_NONE;
    result_o.phys   = '0;
    result_o.strobe = 1'b0;
    case (kind) inside
      KIND_CPU_RD, KIND_CPU_WR: begin
        if (address_i[15:13] == 3'b011) begin
          if (!state_i.ram_disable) begin
            result_o.target = TGT_PRG_RAM;
            result_o.phys   = {5'd0, address_i[12:0]} & ram_mask;
            result_o.strobe = (kind == KIND_CPU_WR);
          end
        end else if (address_i[15]) begin
          if (kind == KIND_CPU_RD) begin
            result_o.target = TGT_PRG_ROM;
            result_o.phys   = prg_raw & rom_mask;
          end else if (write_data_i[7]) begin
            state_o.loader_bits  = '0;
            state_o.loader_count = '0;
            state_o.prg_mode     = PRG_MODE_FIX_LAST;
            state_o.chr_mode     = 1'b0;
            state_o.mirror_mode  = cfg_i.init_mirror;
          end else if (state_i.loader_count == 3'(LoadLast)) begin
            state_o.loader_bits  = '0;
            state_o.loader_count = '0;
            unique case (reg_sel_e'(address_i[14:13]))
              REG_CONTROL: begin
                state_o.mirror_mode = mirror_e'(bits_n[1:0]);
                state_o.prg_mode    = prg_mode_e'(bits_n[3:2]);
                state_o.chr_mode    = bits_n[4];
              end
              REG_CHR0: state_o.chr_bank_low  = bits_n;
              REG_CHR1: state_o.chr_bank_high = bits_n;
              REG_PRG: begin
                state_o.prg_bank_sel = bits_n[3:0];
                state_o.ram_disable  = bits_n[4];
              end
              default: ;
            endcase
          end else begin
            state_o.loader_bits  = bits_n;
            state_o.loader_count = state_i.loader_count + 3'd1;
          end
        end
      end
      KIND_PPU_RD, KIND_PPU_WR: begin
        if (address_i[15:13] == 3'b000) begin
          result_o.target = TGT_CHR;
          result_o.phys   = chr_raw & chr_mask;
          result_o.strobe = (kind == KIND_PPU_WR);
        end
      end
      KIND_NT_FOLD: begin
        result_o.target = TGT_NT;
        result_o.phys   = {2'b00, nt_addr};
      end
      default: ;
    endcase
    result_o.wr_byte = result_o.strobe ? write_data_i : 8'd0;
    result_o.mirror  = state_o.mirror_mode;
  end

endmodule

// File: rtl/serial_loaded_bank_mapper.sv
`timescale 1ns / 1ps
// serial_loaded_bank_mapper: top level, input stage, mapper state and result register
// depends on sbm_pkg and sbm_xlate
//
// channel | direction | handshake            | payload
// in      | sink      | in_valid_i/in_ready_o   | kind_i, address_i, write_data_i
// out     | source    | out_valid_o/out_ready_i | target_o, phys_address_o,
//         |           |                         | write_strobe_o, write_byte_o,
//         |           |                         | mirroring_now_o
// cfg     | sink      | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// one transfer per cycle unless the output stalls; input stage, then result register
// translation and the mapper state update happen as an item leaves the input stage
// a stalled output holds its result while one more item waits in the input stage
// reset sets config, state and valid flags but not data; mirroring starts single low

module serial_loaded_bank_mapper import sbm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          kind_i,
  input  logic [AddrW-1:0]    address_i,
  input  logic [7:0]          write_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          target_o,
  output logic [PhysW-1:0]    phys_address_o,
  output logic                write_strobe_o,
  output logic [7:0]          write_byte_o,
  output logic [1:0]          mirroring_now_o
);

  cfg_t             cfg_q;
  state_t           state_q;
  state_t           state_d;
  result_t          result_d;
  result_t          result_q;
  logic             s1_valid_q;
  logic [2:0]       s1_kind_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [7:0]       s1_data_q;
  logic             out_valid_q;
  logic             s1_move;

  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prg_rom_lg  <= PrgRomLog2Rst;
      cfg_q.chr_lg      <= ChrLog2Rst;
      cfg_q.prg_ram_lg  <= PrgRamLog2Rst;
      cfg_q.init_mirror <= MIR_SINGLE_LO;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PRG_ROM_LOG2: cfg_q.prg_rom_lg  <= cfg_data_i;
        CFG_CHR_LOG2:     cfg_q.chr_lg      <= cfg_data_i;
        CFG_PRG_RAM_LOG2: cfg_q.prg_ram_lg  <= cfg_data_i[3:0];
        CFG_INIT_MIRROR:  cfg_q.init_mirror <= mirror_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_kind_q <= kind_i;
      s1_addr_q <= address_i;
      s1_data_q <= write_data_i;
    end
  end

  sbm_xlate u_xlate (
    .cfg_i        (cfg_q),
    .state_i      (state_q),
    .kind_i       (s1_kind_q),
    .address_i    (s1_addr_q),
    .write_data_i (s1_data_q),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  // mapper state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.loader_bits   <= '0;
      state_q.loader_count  <= '0;
      state_q.prg_mode      <= PRG_MODE_FIX_LAST;
      state_q.chr_mode      <= 1'b0;
      state_q.chr_bank_low  <= '0;
      state_q.chr_bank_high <= '0;
      state_q.prg_bank_sel  <= '0;
      state_q.ram_disable   <= 1'b0;
      state_q.mirror_mode   <= MIR_SINGLE_LO;
    end else if (s1_move) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign target_o        = result_q.target;
  assign phys_address_o  = result_q.phys;
  assign write_strobe_o  = result_q.strobe;
  assign write_byte_o    = result_q.wr_byte;
  assign mirroring_now_o = result_q.mirror;

endmodule

// File: rtl/sbm_checker.sv
`timescale 1ns / 1ps
// sbm_checker: port level checks for serial_loaded_bank_mapper, with its bind
// depends on sbm_pkg

module sbm_checker import sbm_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [2:0]       target_o,
  input logic [PhysW-1:0] phys_address_o,
  input logic             write_strobe_o,
  input logic [7:0]       write_byte_o
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // input side only backs up behind a stalled result
  a_in_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

  a_strobe_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_strobe_o |->
      (target_o == TGT_PRG_RAM || target_o == TGT_CHR))
    else $error("write strobe on a read-only target");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && target_o == TGT_NONE |->
      phys_address_o == '0 && write_byte_o == '0 && !write_strobe_o)
    else $error("unmapped transfer carries data");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_strobe_o |-> write_byte_o == '0)
    else $error("write byte set without strobe");

endmodule

bind serial_loaded_bank_mapper sbm_checker u_sbm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .target_o       (target_o),
  .phys_address_o (phys_address_o),
  .write_strobe_o (write_strobe_o),
  .write_byte_o   (write_byte_o)
);
